// ----- sv/esa_pkg.sv -----
// ----------------------------------------------------------------------------
// esa_pkg
// Shared types, widths and codes for the encoder setpoint block.
// ----------------------------------------------------------------------------
package esa_pkg;

  localparam int SETPOINT_BITS = 12;
  localparam int SPEED_BITS    = 9;

  // fixed register and field widths
  localparam int SP_FIELD_BITS  = 12;
  localparam int SPD_MAX_BITS   = 9;
  localparam int SPD_INC_BITS   = 8;
  localparam int SPD_DEC_BITS   = 9;
  localparam int HOLD_BITS      = 4;
  localparam int SHOW_BITS      = 3;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 12;

  // compare and sum widths
  localparam int GROW_W = ((SPEED_BITS > SPD_INC_BITS) ? SPEED_BITS : SPD_INC_BITS) + 1;
  localparam int SMAX_W = (SPEED_BITS > SPD_MAX_BITS) ? SPEED_BITS : SPD_MAX_BITS;
  localparam int DEC_W  = (SPEED_BITS > SPD_DEC_BITS) ? SPEED_BITS : SPD_DEC_BITS;
  localparam int LSUM_W = ((SETPOINT_BITS > SPEED_BITS) ? SETPOINT_BITS : SPEED_BITS) + 1;

  localparam logic [SPEED_BITS-1:0] SPEED_MASK = '1;

  localparam logic [SP_FIELD_BITS-1:0] SETPOINT_MAX_RST = 12'd4095;
  localparam logic [SPD_MAX_BITS-1:0]  SPEED_MAX_RST    = 9'd256;
  localparam logic [SPD_INC_BITS-1:0]  SPEED_INC_RST    = 8'h10;
  localparam logic [SPD_DEC_BITS-1:0]  SPEED_DEC_RST    = 9'h040;
  localparam logic [HOLD_BITS-1:0]     HOLD_TICKS_RST   = 4'd8;
  localparam logic [SHOW_BITS-1:0]     SHOW_TICKS_RST   = 3'd4;

  typedef enum logic [1:0] {
    OP_ENC  = 2'd0,
    OP_BTN  = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SETPOINT_MAX = 3'd0,
    CFG_SPEED_MAX    = 3'd1,
    CFG_SPEED_INC    = 3'd2,
    CFG_SPEED_DEC    = 3'd3,
    CFG_HOLD_TICKS   = 3'd4,
    CFG_SHOW_TICKS   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [SP_FIELD_BITS-1:0] setpoint_max;
    logic [SPD_MAX_BITS-1:0]  speed_max;
    logic [SPD_INC_BITS-1:0]  speed_inc;
    logic [SPD_DEC_BITS-1:0]  speed_dec;
    logic [HOLD_BITS-1:0]     hold_ticks;
    logic [SHOW_BITS-1:0]     show_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic       enc_a_low;
    logic       enc_b_low;
    logic       button_pressed;
  } item_t;

  typedef struct packed {
    logic [SP_FIELD_BITS-1:0] setpoint;
    logic                     locked;
    logic                     show_setpoint;
    logic [1:0]               step;
  } result_t;

endpackage

// ----- sv/esa_src_if.sv -----
// ----------------------------------------------------------------------------
// esa_src_if
// Input item channel: op code, encoder pin levels and button level.
// ----------------------------------------------------------------------------
interface esa_src_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       enc_a_low;
  logic       enc_b_low;
  logic       button_pressed;

  modport source (output valid, op, enc_a_low, enc_b_low, button_pressed, input ready);
  modport sink   (input valid, op, enc_a_low, enc_b_low, button_pressed, output ready);
endinterface

// ----- sv/esa_res_if.sv -----
// ----------------------------------------------------------------------------
// esa_res_if
// Result item channel: setpoint, lock, show flag and detent step.
// ----------------------------------------------------------------------------
interface esa_res_if;
  logic        valid;
  logic        ready;
  logic [11:0] setpoint;
  logic        locked;
  logic        show_setpoint;
  logic [1:0]  step;

  modport source (output valid, setpoint, locked, show_setpoint, step, input ready);
  modport sink   (input valid, setpoint, locked, show_setpoint, step, output ready);
endinterface

// ----- sv/esa_cfg_if.sv -----
// ----------------------------------------------------------------------------
// esa_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface esa_cfg_if import esa_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/esa_cfg.sv -----
// ----------------------------------------------------------------------------
// esa_cfg
// Configuration register file, written one register per handshake.
// ----------------------------------------------------------------------------
module esa_cfg import esa_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  esa_cfg_if.sink cfg,
  output cfg_t   regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.setpoint_max <= SETPOINT_MAX_RST;
      regs.speed_max    <= SPEED_MAX_RST;
      regs.speed_inc    <= SPEED_INC_RST;
      regs.speed_dec    <= SPEED_DEC_RST;
      regs.hold_ticks   <= HOLD_TICKS_RST;
      regs.show_ticks   <= SHOW_TICKS_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SETPOINT_MAX: regs.setpoint_max <= cfg.data[SP_FIELD_BITS-1:0];
        CFG_SPEED_MAX:    regs.speed_max    <= cfg.data[SPD_MAX_BITS-1:0];
        CFG_SPEED_INC:    regs.speed_inc    <= cfg.data[SPD_INC_BITS-1:0];
        CFG_SPEED_DEC:    regs.speed_dec    <= cfg.data[SPD_DEC_BITS-1:0];
        CFG_HOLD_TICKS:   regs.hold_ticks   <= cfg.data[HOLD_BITS-1:0];
        CFG_SHOW_TICKS:   regs.show_ticks   <= cfg.data[SHOW_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/esa_core.sv -----
// ----------------------------------------------------------------------------
// esa_core
// Quadrature tracker, speed and setpoint update, show timer and hold lock.
// ----------------------------------------------------------------------------
module esa_core import esa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam logic [1:0] PH_NONE = 2'b00;
  localparam logic [1:0] PH_A    = 2'b01;
  localparam logic [1:0] PH_B    = 2'b10;
  localparam logic [1:0] PH_BOTH = 2'b11;

  localparam int EF_FIRST_UP = 0;
  localparam int EF_FIRST_DN = 1;
  localparam int EF_LAST_UP  = 2;
  localparam int EF_LAST_DN  = 3;
  localparam int EF_MID      = 4;

  typedef struct packed {
    logic [1:0]               phase_prev;
    logic                     phase_valid;
    logic [4:0]               edge_flags;
    logic [SPEED_BITS-1:0]    speed;
    logic [SETPOINT_BITS-1:0] level;
    logic                     recent_action;
    logic [SHOW_BITS-1:0]     show_timer;
    logic                     holding;
    logic                     release_pending;
    logic [HOLD_BITS-1:0]     hold_count;
    logic                     lock_flag;
  } state_t;

  state_t                   st;
  state_t                   st_next;
  step_t                    dir;
  logic [SPEED_BITS-1:0]    spd_grow;
  logic [SPEED_BITS-1:0]    spd_decay;
  logic [SETPOINT_BITS-1:0] lvl_up;
  logic [SETPOINT_BITS-1:0] lvl_dn;

  // speed and level arithmetic
  always_comb begin
    logic [GROW_W-1:0]        gsum;
    logic [LSUM_W-1:0]        usum;
    logic [SETPOINT_BITS-1:0] lim;
    gsum = GROW_W'(st.speed) + GROW_W'(cfg.speed_inc);
    if (st.speed == '0) begin
      spd_grow = SPEED_BITS'(1);
    end else if (SMAX_W'(st.speed) < SMAX_W'(cfg.speed_max)) begin
      spd_grow = (gsum > GROW_W'(SPEED_MASK)) ? SPEED_MASK : SPEED_BITS'(gsum);
    end else begin
      spd_grow = st.speed;
    end

    if (DEC_W'(st.speed) > DEC_W'(cfg.speed_dec)) begin
      spd_decay = SPEED_BITS'(DEC_W'(st.speed) - DEC_W'(cfg.speed_dec));
    end else begin
      spd_decay = '0;
    end

    lim  = SETPOINT_BITS'(cfg.setpoint_max);
    usum = st.lock_flag ? LSUM_W'(st.level) : LSUM_W'(st.level) + LSUM_W'(spd_grow);
    lvl_up = (usum > LSUM_W'(lim)) ? lim : SETPOINT_BITS'(usum);

    if (st.lock_flag) begin
      lvl_dn = st.level;
    end else if (LSUM_W'(spd_grow) > LSUM_W'(st.level)) begin
      lvl_dn = '0;
    end else begin
      lvl_dn = SETPOINT_BITS'(LSUM_W'(st.level) - LSUM_W'(spd_grow));
    end
  end

  // next state
  always_comb begin
    logic [1:0] cur;
    logic [4:0] fl;
    logic       up;
    logic       dn;
    st_next = st;
    dir     = STEP_NONE;
    cur     = {item.enc_b_low, item.enc_a_low};
    fl      = st.edge_flags;
    up      = 1'b0;
    dn      = 1'b0;
    case (item.op)
      OP_ENC: begin
        if (!st.phase_valid) begin
          st_next.phase_prev  = cur;
          st_next.phase_valid = 1'b1;
        end else if (cur != st.phase_prev) begin
          if (st.phase_prev == PH_NONE) begin
            if (cur == PH_A) begin
              fl[EF_FIRST_UP] = 1'b1;
            end else if (cur == PH_B) begin
              fl[EF_FIRST_DN] = 1'b1;
            end
          end
          if (cur == PH_BOTH) begin
            fl[EF_MID] = 1'b1;
          end else if (cur == PH_NONE) begin
            if (st.phase_prev == PH_B) begin
              fl[EF_LAST_UP] = 1'b1;
            end else if (st.phase_prev == PH_A) begin
              fl[EF_LAST_DN] = 1'b1;
            end
            up = (fl[EF_FIRST_UP] && fl[EF_LAST_UP]) || (fl[EF_FIRST_UP] && fl[EF_MID]) ||
                 (fl[EF_LAST_UP] && fl[EF_MID]);
            dn = (fl[EF_FIRST_DN] && fl[EF_LAST_DN]) || (fl[EF_FIRST_DN] && fl[EF_MID]) ||
                 (fl[EF_LAST_DN] && fl[EF_MID]);
            if (up) begin
              dir = STEP_UP;
            end else if (dn) begin
              dir = STEP_DOWN;
            end
            fl = '0;
          end
          st_next.edge_flags = fl;
          st_next.phase_prev = cur;
        end
        if (dir != STEP_NONE) begin
          st_next.recent_action = 1'b1;
          st_next.speed         = spd_grow;
          st_next.level         = (dir == STEP_UP) ? lvl_up : lvl_dn;
          st_next.show_timer    = cfg.show_ticks;
        end
      end
      OP_BTN: begin
        if (item.button_pressed) begin
          st_next.show_timer = cfg.show_ticks;
          if (!st.release_pending) begin
            st_next.holding = 1'b1;
          end
        end else begin
          st_next.holding         = 1'b0;
          st_next.release_pending = 1'b0;
          st_next.hold_count      = '0;
        end
      end
      OP_TICK: begin
        if (st.recent_action) begin
          st_next.recent_action = 1'b0;
        end else begin
          st_next.speed = spd_decay;
          if (st.show_timer != '0) begin
            st_next.show_timer = st.show_timer - 1'b1;
          end
        end
        if (st.holding) begin
          if (st.hold_count < cfg.hold_ticks) begin
            st_next.hold_count = st.hold_count + 1'b1;
          end else begin
            st_next.holding         = 1'b0;
            st_next.release_pending = 1'b1;
            st_next.hold_count      = '0;
            st_next.lock_flag       = ~st.lock_flag;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (en) begin
      st <= st_next;
    end
  end

  assign result.setpoint      = SP_FIELD_BITS'(st_next.level);
  assign result.locked        = st_next.lock_flag;
  assign result.show_setpoint = (st_next.show_timer != '0);
  assign result.step          = dir;

endmodule

// ----- sv/encoder_setpoint_with_acceleration_top.sv -----
// ----------------------------------------------------------------------------
// encoder_setpoint_with_acceleration_top
// Rotary encoder setpoint with detent debounce, acceleration and button lock.
// ----------------------------------------------------------------------------
// Every input item (encoder sample, button sample, tick or unused op code)
// gives exactly one result item. Items pass through an input register and a
// result register with the whole state update in between, so one item is
// taken per clock while the result side is not stalled. An accepted item
// waits in the input register; its result is then loaded into the result
// register and offered on the result channel. The state update of one item
// is the only loop. The result register frees the input side from a stalled
// consumer until both registers are full.
// Configuration writes are taken at any time and are meant for an idle block.
module encoder_setpoint_with_acceleration_top import esa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  esa_src_if.sink   src,
  esa_res_if.source res,
  esa_cfg_if.sink   cfg
);

  cfg_t    regs;
  item_t   s1_item;
  logic    s1_valid;
  logic    adv;
  logic    fire;
  result_t core_res;
  result_t res_data;
  logic    res_valid;

  esa_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  esa_core u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (fire),
    .item   (s1_item),
    .cfg    (regs),
    .result (core_res)
  );

  assign adv       = !res_valid || res.ready;
  assign fire      = s1_valid && adv;
  assign src.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (src.ready) begin
      s1_valid <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src.valid && src.ready) begin
      s1_item.op             <= src.op;
      s1_item.enc_a_low      <= src.enc_a_low;
      s1_item.enc_b_low      <= src.enc_b_low;
      s1_item.button_pressed <= src.button_pressed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_data <= core_res;
    end
  end

  assign res.valid         = res_valid;
  assign res.setpoint      = res_data.setpoint;
  assign res.locked        = res_data.locked;
  assign res.show_setpoint = res_data.show_setpoint;
  assign res.step          = res_data.step;

  // detents come only from encoder samples
  a_step_from_enc: assert property (@(posedge clk) disable iff (rst)
    fire && core_res.step != STEP_NONE |-> s1_item.op == OP_ENC)
    else $error("detent reported for a non-encoder item");

  a_step_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.step == STEP_NONE || res_data.step == STEP_UP ||
                   res_data.step == STEP_DOWN))
    else $error("bad step code in result");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(s1_item))
    else $error("input register lost a stalled item");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    src.valid && src.ready |-> !s1_valid || adv)
    else $error("item accepted over a held item");

endmodule

// ----- dv/encoder_setpoint_with_acceleration_top_test.sv -----
// ----------------------------------------------------------------------------
// encoder_setpoint_with_acceleration_top_test
// Drives encoder samples, button samples and ticks into the setpoint block
// through its source channel, predicts every result item from a local copy
// of the detent tracker, speed, setpoint and lock state, and checks each
// result field. Runs several register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module encoder_setpoint_with_acceleration_top_test;
  import esa_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  // encoder phase: bit0 = A low, bit1 = B low
  localparam logic [1:0] PH_REST = 2'b00;
  localparam logic [1:0] PH_A    = 2'b01;
  localparam logic [1:0] PH_B    = 2'b10;
  localparam logic [1:0] PH_BOTH = 2'b11;

  localparam int EF_FIRST_UP = 0;
  localparam int EF_FIRST_DN = 1;
  localparam int EF_LAST_UP  = 2;
  localparam int EF_LAST_DN  = 3;
  localparam int EF_MIDDLE   = 4;

  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PASS = 125;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 8;

  typedef struct {
    item_t it;
    bit    hold_for_drain;
  } queued_sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  esa_src_if src_bus();
  esa_res_if res_bus();
  esa_cfg_if cfg_bus();

  encoder_setpoint_with_acceleration_top dut (
    .clk (clk),
    .rst (rst),
    .src (src_bus),
    .res (res_bus),
    .cfg (cfg_bus)
  );

  always #5 clk = ~clk;

  // local copy of the block state and registers
  cfg_t regs = '{
    setpoint_max: SETPOINT_MAX_RST,
    speed_max:    SPEED_MAX_RST,
    speed_inc:    SPEED_INC_RST,
    speed_dec:    SPEED_DEC_RST,
    hold_ticks:   HOLD_TICKS_RST,
    show_ticks:   SHOW_TICKS_RST
  };
  logic [1:0]               ph_last      = '0;
  logic                     ph_primed    = 1'b0;
  logic [4:0]               edge_seen    = '0;
  logic [SPEED_BITS-1:0]    step_speed   = '0;
  logic [SETPOINT_BITS-1:0] level        = '0;
  logic                     action_seen  = 1'b0;
  logic [SHOW_BITS-1:0]     show_left    = '0;
  logic                     btn_holding  = 1'b0;
  logic                     wait_release = 1'b0;
  logic [HOLD_BITS-1:0]     held_ticks   = '0;
  logic                     locked_now   = 1'b0;

  queued_sample_t sample_queue[$];
  queued_sample_t head_sample;
  item_t          on_wire;
  result_t        pending_readouts[$];
  result_t        want;

  int  src_idle_pct   = 0;
  int  res_stall_pct  = 0;
  int  mismatch_count = 0;
  int  quiet_cycles   = 0;
  int  stim_count     = 0;
  bit  drain_next     = 1'b0;
  bit  turn_up        = 1'b1;

  function automatic result_t next_setpoint_state(item_t it);
    logic [1:0]        cur;
    step_t             dir;
    logic [GROW_W-1:0] grown;
    logic [LSUM_W-1:0] raised;
    result_t           r;
    dir = STEP_NONE;
    case (it.op)
      OP_ENC: begin
        cur = {it.enc_b_low, it.enc_a_low};
        if (!ph_primed) begin
          ph_last   = cur;
          ph_primed = 1'b1;
        end else if (cur != ph_last) begin
          if (ph_last == PH_REST) begin
            if (cur == PH_A) edge_seen[EF_FIRST_UP] = 1'b1;
            else if (cur == PH_B) edge_seen[EF_FIRST_DN] = 1'b1;
          end
          if (cur == PH_BOTH) begin
            edge_seen[EF_MIDDLE] = 1'b1;
          end else if (cur == PH_REST) begin
            if (ph_last == PH_B) edge_seen[EF_LAST_UP] = 1'b1;
            else if (ph_last == PH_A) edge_seen[EF_LAST_DN] = 1'b1;
            if ((edge_seen[EF_FIRST_UP] && (edge_seen[EF_LAST_UP] || edge_seen[EF_MIDDLE])) ||
                (edge_seen[EF_LAST_UP] && (edge_seen[EF_FIRST_UP] || edge_seen[EF_MIDDLE])))
              dir = STEP_UP;
            else if ((edge_seen[EF_FIRST_DN] &&
                      (edge_seen[EF_LAST_DN] || edge_seen[EF_MIDDLE])) ||
                     (edge_seen[EF_LAST_DN] &&
                      (edge_seen[EF_FIRST_DN] || edge_seen[EF_MIDDLE])))
              dir = STEP_DOWN;
            edge_seen = '0;
          end
          ph_last = cur;
        end
        if (dir != STEP_NONE) begin
          action_seen = 1'b1;
          if (step_speed == '0) begin
            step_speed = SPEED_BITS'(1);
          end else if (step_speed < regs.speed_max) begin
            grown = GROW_W'(step_speed) + GROW_W'(regs.speed_inc);
            step_speed = (grown > GROW_W'(SPEED_MASK)) ? SPEED_MASK : grown[SPEED_BITS-1:0];
          end
          if (dir == STEP_UP) begin
            raised = LSUM_W'(level);
            if (!locked_now) raised = raised + LSUM_W'(step_speed);
            level = (raised > LSUM_W'(regs.setpoint_max)) ? regs.setpoint_max :
                                                           raised[SETPOINT_BITS-1:0];
          end else if (!locked_now) begin
            level = (SETPOINT_BITS'(step_speed) > level) ? '0 :
                                                           level - SETPOINT_BITS'(step_speed);
          end
          show_left = regs.show_ticks;
        end
      end
      OP_BTN: begin
        if (it.button_pressed) begin
          show_left = regs.show_ticks;
          if (!wait_release) btn_holding = 1'b1;
        end else begin
          btn_holding  = 1'b0;
          wait_release = 1'b0;
          held_ticks   = '0;
        end
      end
      OP_TICK: begin
        if (show_left != '0 && !action_seen) show_left = show_left - 1'b1;
        if (!action_seen)
          step_speed = (step_speed > regs.speed_dec) ? step_speed - regs.speed_dec : '0;
        else
          action_seen = 1'b0;
        if (btn_holding) begin
          if (held_ticks < regs.hold_ticks) begin
            held_ticks = held_ticks + 1'b1;
          end else begin
            btn_holding  = 1'b0;
            wait_release = 1'b1;
            held_ticks   = '0;
            locked_now   = ~locked_now;
          end
        end
      end
      default: begin
      end
    endcase
    r.setpoint      = level;
    r.locked        = locked_now;
    r.show_setpoint = (show_left != '0);
    r.step          = dir;
    return r;
  endfunction

  // source driver
  always @(posedge clk) begin
    if (rst) begin
      src_bus.valid <= 1'b0;
    end else begin
      if (src_bus.valid && src_bus.ready)
        pending_readouts.push_back(next_setpoint_state(on_wire));
      if (src_bus.valid && !src_bus.ready) begin
        // stalled, keep the item
      end else if (sample_queue.size() != 0 &&
                   !(sample_queue[0].hold_for_drain && pending_readouts.size() != 0) &&
                   $urandom_range(0, 99) >= src_idle_pct) begin
        head_sample = sample_queue.pop_front();
        on_wire = head_sample.it;
        src_bus.valid          <= 1'b1;
        src_bus.op             <= on_wire.op;
        src_bus.enc_a_low      <= on_wire.enc_a_low;
        src_bus.enc_b_low      <= on_wire.enc_b_low;
        src_bus.button_pressed <= on_wire.button_pressed;
      end else begin
        src_bus.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (pending_readouts.size() == 0) begin
          $error("result item with none expected: setpoint %0d", res_bus.setpoint);
          mismatch_count++;
        end else begin
          want = pending_readouts.pop_front();
          if (res_bus.setpoint !== want.setpoint) begin
            $error("setpoint: expected %0d, got %0d", want.setpoint, res_bus.setpoint);
            mismatch_count++;
          end
          if (res_bus.locked !== want.locked) begin
            $error("locked: expected %0d, got %0d", want.locked, res_bus.locked);
            mismatch_count++;
          end
          if (res_bus.show_setpoint !== want.show_setpoint) begin
            $error("show_setpoint: expected %0d, got %0d", want.show_setpoint,
                   res_bus.show_setpoint);
            mismatch_count++;
          end
          if (res_bus.step !== want.step) begin
            $error("step: expected %0d, got %0d", want.step, res_bus.step);
            mismatch_count++;
          end
        end
      end
      res_bus.ready <= ($urandom_range(0, 99) >= res_stall_pct);
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (rst || (src_bus.valid && src_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_item(logic [1:0] op, logic a_low, logic b_low, logic pressed);
    queued_sample_t q;
    q.it.op             = op;
    q.it.enc_a_low      = a_low;
    q.it.enc_b_low      = b_low;
    q.it.button_pressed = pressed;
    q.hold_for_drain    = drain_next;
    drain_next = 1'b0;
    sample_queue.push_back(q);
    if (op != OP_UNUSED) stim_count++;
  endtask

  task automatic add_sample(logic [1:0] ph);
    push_item(OP_ENC, ph[0], ph[1], 1'($urandom_range(0, 1)));
  endtask

  task automatic add_tick();
    push_item(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic add_button(logic pressed);
    push_item(OP_BTN, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pressed);
  endtask

  // one detent, optionally with contact bounce and repeated levels
  task automatic add_turn(bit up, bit bouncy);
    logic [1:0] path [4];
    logic [1:0] prev;
    if (up) path = '{PH_A, PH_BOTH, PH_B, PH_REST};
    else    path = '{PH_B, PH_BOTH, PH_A, PH_REST};
    prev = PH_REST;
    for (int s = 0; s < 4; s++) begin
      add_sample(path[s]);
      if (bouncy && $urandom_range(0, 3) == 0) begin
        add_sample(prev);
        add_sample(path[s]);
      end
      if ($urandom_range(0, 7) == 0) add_sample(path[s]);
      prev = path[s];
    end
  endtask

  task automatic add_burst();
    int pick;
    int n;
    logic [1:0] first;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if ($urandom_range(0, 9) < 3) turn_up = !turn_up;
      n = $urandom_range(1, 8);
      for (int d = 0; d < n; d++) begin
        add_turn(turn_up, $urandom_range(0, 9) < 3);
        if ($urandom_range(0, 9) == 0) add_tick();
      end
    end else if (pick < 60) begin
      n = $urandom_range(1, 3);
      for (int t = 0; t < n; t++) add_tick();
    end else if (pick < 68) begin
      add_button(1'b1);
      n = $urandom_range(0, int'(regs.hold_ticks) + 2);
      for (int t = 0; t < n; t++) begin
        add_tick();
        if ($urandom_range(0, 3) == 0) add_button(1'b1);
      end
      if ($urandom_range(0, 4) != 0) add_button(1'b0);
    end else if (pick < 78) begin
      add_button(1'($urandom_range(0, 1)));
    end else if (pick < 88) begin
      add_sample(2'($urandom_range(0, 3)));
    end else if (pick < 93) begin
      push_item(OP_UNUSED, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end else begin
      // turn started and then backed out
      first = $urandom_range(0, 1) ? PH_A : PH_B;
      add_sample(first);
      if ($urandom_range(0, 1)) begin
        add_sample(PH_BOTH);
        add_sample(first);
      end
      add_sample(PH_REST);
    end
  endtask

  // checked away from the rising edge so driver and monitor updates have settled
  task automatic wait_idle();
    while (sample_queue.size() != 0 || src_bus.valid || pending_readouts.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    case (idx)
      CFG_SETPOINT_MAX: regs.setpoint_max = val[SP_FIELD_BITS-1:0];
      CFG_SPEED_MAX:    regs.speed_max    = val[SPD_MAX_BITS-1:0];
      CFG_SPEED_INC:    regs.speed_inc    = val[SPD_INC_BITS-1:0];
      CFG_SPEED_DEC:    regs.speed_dec    = val[SPD_DEC_BITS-1:0];
      CFG_HOLD_TICKS:   regs.hold_ticks   = val[HOLD_BITS-1:0];
      CFG_SHOW_TICKS:   regs.show_ticks   = val[SHOW_BITS-1:0];
      default: begin
      end
    endcase
  endtask

  initial begin
    logic [CFG_DATA_BITS-1:0] vals [6];
    int target;
    int half;
    bit mid_done;

    src_bus.valid          = 1'b0;
    src_bus.op             = OP_ENC;
    src_bus.enc_a_low      = 1'b0;
    src_bus.enc_b_low      = 1'b0;
    src_bus.button_pressed = 1'b0;
    res_bus.ready          = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = CFG_SETPOINT_MAX;
    cfg_bus.data           = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        case (p)
          1: vals = '{12'd4095, 12'd511, 12'd255, 12'd511, 12'd15, 12'd7};
          2: vals = '{12'd0, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1};
          3: vals = '{12'd100, 12'hE00, 12'hF00, 12'hE00, 12'hFF0, 12'hFF8};
          default: foreach (vals[i]) vals[i] = CFG_DATA_BITS'($urandom_range(0, 4095));
        endcase
        for (int i = 0; i < 6; i++) write_reg(cfg_idx_t'(i), vals[i]);
      end

      case (p % 4)
        0: begin src_idle_pct = 0;  res_stall_pct = 0;  end
        1: begin src_idle_pct = 52; res_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  res_stall_pct = 52; end
        default: begin src_idle_pct = 8; res_stall_pct = 8; end
      endcase

      if (p == 0) begin
        push_item(OP_UNUSED, 1'b1, 1'b1, 1'b1);
        add_sample(PH_REST);
        add_sample(PH_REST);
        add_turn(1'b1, 1'b0);
        add_turn(1'b0, 1'b0);
        add_tick();
        add_tick();
        add_button(1'b1);
        repeat (9) add_tick();
        add_button(1'b1);
        add_button(1'b0);
      end

      target   = stim_count + ITEMS_PER_PASS;
      half     = stim_count + ITEMS_PER_PASS / 2;
      mid_done = 1'b0;
      while (stim_count < target) begin
        if (!mid_done && stim_count >= half) begin
          drain_next = 1'b1;
          mid_done   = 1'b1;
        end
        add_burst();
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/esa_pkg.sv
sv/esa_src_if.sv
sv/esa_res_if.sv
sv/esa_cfg_if.sv
sv/esa_cfg.sv
sv/esa_core.sv
sv/encoder_setpoint_with_acceleration_top.sv
dv/encoder_setpoint_with_acceleration_top_test.sv
